// File: rtl/core/coordinate_keyed_index_table_macros.svh
// assertion macros for the coordinate keyed index table checker
// expects signals clk and rst_n in the scope of use
`ifndef COORDINATE_KEYED_INDEX_TABLE_MACROS_SVH
`define COORDINATE_KEYED_INDEX_TABLE_MACROS_SVH

// same-cycle implication, disabled in reset
`define CKIT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CKIT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ckit_pkg.sv
// shared types and codes for the coordinate keyed index table
// no dependencies
package ckit_pkg;

  localparam int CAPACITY_DEF = 256;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [1:0] {
    STAT_LOOKUP = 2'd0,
    STAT_UPDATE = 2'd1,
    STAT_APPEND = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] column;
    logic [15:0] row_key;
    logic [31:0] value;
  } entry_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] value_out;
    status_t     status;
  } result_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// File: rtl/core/ckit_if.sv
// valid/ready channel interfaces for the item and result beats
// no dependencies
interface ckit_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] column;
  logic [15:0] row_key;
  logic [31:0] value_in;

  modport source (output valid, opcode, column, row_key, value_in, input ready);
  modport sink   (input valid, opcode, column, row_key, value_in, output ready);
endinterface

interface ckit_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] value_out;
  logic [1:0]  status;

  modport source (output valid, hit, value_out, status, input ready);
  modport sink   (input valid, hit, value_out, status, output ready);
endinterface

// File: rtl/core/ckit_mem.sv
// entry store: one write port, one read port with registered read data
// depends on ckit_pkg
module ckit_mem #(
  parameter int CAPACITY = ckit_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  ckit_pkg::mem_ctl_t           mem_ctl,
  input  logic [$clog2(CAPACITY)-1:0]  rd_addr,
  input  logic [$clog2(CAPACITY)-1:0]  wr_addr,
  input  ckit_pkg::entry_t             wr_data,
  output ckit_pkg::entry_t             rd_data
);
  import ckit_pkg::*;

  entry_t mem [CAPACITY];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/ckit_ctrl.sv
// search sequencer: scans stored entries, then updates or appends
// depends on ckit_pkg, drives ckit_mem
module ckit_ctrl #(
  parameter int CAPACITY = ckit_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_fire,
  input  logic                         in_opcode,
  input  logic [15:0]                  in_column,
  input  logic [15:0]                  in_row_key,
  input  logic [31:0]                  in_value_in,
  output logic                         in_ready,
  output ckit_pkg::mem_ctl_t           mem_ctl,
  output logic [$clog2(CAPACITY)-1:0]  rd_addr,
  output logic [$clog2(CAPACITY)-1:0]  wr_addr,
  output ckit_pkg::entry_t             wr_data,
  input  ckit_pkg::entry_t             rd_data,
  output logic                         res_valid,
  input  logic                         res_ready,
  output ckit_pkg::result_t            res
);
  import ckit_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t             state_r, state_nxt;
  logic               op_r;
  logic [15:0]        col_r;
  logic [15:0]        row_r;
  logic [31:0]        val_r;
  logic [CNT_W-1:0]   rd_idx_r;
  logic               cmp_vld_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic               found_r;
  logic [IDX_W-1:0]   pos_r;
  logic [31:0]        fval_r;
  logic [CNT_W-1:0]   count_r;

  logic issue;
  logic key_match;
  logic scan_miss;
  logic full;
  logic done_fire;
  logic do_write;

  assign key_match = cmp_vld_r && (rd_data.column == col_r) && (rd_data.row_key == row_r);
  assign full      = (count_r == CNT_W'(CAPACITY));
  // every entry issued and the last compare (if any) missed
  assign scan_miss = (rd_idx_r == count_r) && !key_match;
  assign done_fire = (state_r == ST_DONE) && res_ready;
  assign do_write  = done_fire && (op_r == OP_INSERT) && (found_r || !full);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (key_match || scan_miss) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    issue         = 1'b0;
    res_valid     = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: issue = (rd_idx_r < count_r) && !key_match;
      ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
    mem_ctl.rd_en = issue;
    mem_ctl.wr_en = do_write;
    rd_addr       = rd_idx_r[IDX_W-1:0];
    wr_addr       = found_r ? pos_r : count_r[IDX_W-1:0];
    wr_data       = '{column: col_r, row_key: row_r, value: val_r};

    res.hit       = found_r;
    res.value_out = (op_r == OP_LOOKUP && found_r) ? fval_r : 32'd0;
    if (op_r == OP_LOOKUP) begin
      res.status = STAT_LOOKUP;
    end else if (found_r) begin
      res.status = STAT_UPDATE;
    end else if (!full) begin
      res.status = STAT_APPEND;
    end else begin
      res.status = STAT_FULL;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= issue;
      if (do_write && !found_r) count_r <= count_r + CNT_W'(1);
    end
  end

  // item and search payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_opcode;
      col_r    <= in_column;
      row_r    <= in_row_key;
      val_r    <= in_value_in;
      rd_idx_r <= '0;
      found_r  <= 1'b0;
    end else begin
      if (issue) rd_idx_r <= rd_idx_r + CNT_W'(1);
      if (state_r == ST_SCAN && key_match) begin
        found_r <= 1'b1;
        pos_r   <= cmp_idx_r;
        fval_r  <= rd_data.value;
      end
    end
    if (issue) cmp_idx_r <= rd_idx_r[IDX_W-1:0];
  end

endmodule

// File: rtl/core/coordinate_keyed_index_table.sv
// top level of the coordinate keyed index table
// depends on ckit_pkg, ckit_if, ckit_ctrl, ckit_mem
//
// Sparse map from a (column, row) key to a 32-bit value, held as a flat
// table of up to CAPACITY entries in one synchronous memory. Each input
// beat is either a lookup or an insert; every beat yields exactly one
// result beat. The table is scanned one entry per cycle through the
// memory's single read port, in the order entries were appended, and the
// first matching key ends the scan. After its beat is taken, an item holds
// the sequencer until its scan ends, whether it hits an entry or misses.
// The sequencer then offers the result beat to the output register, and
// the next input beat is taken only after that result has been accepted
// and the sequencer has gone back to idle.
// One item is worked at a time.
// Inserts write back once the scan ends: a matching key gets its value
// overwritten, a new key is appended at the fill count, and a new key into
// a full table is dropped with status 3. Reset clears the fill count and
// control state, not the entries; no clearing pass is needed, since entries
// at or above the count are never read. A finished result waits in the
// output register, so the next item is taken while that result is unread.
module coordinate_keyed_index_table #(
  parameter int CAPACITY = ckit_pkg::CAPACITY_DEF
) (
  input logic         clk,
  input logic         rst_n,
  ckit_in_if.sink     in_ch,
  ckit_out_if.source  out_ch
);
  import ckit_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);

  // interconnect between the sequencer and the entry store
  mem_ctl_t         mem_ctl;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  entry_t           rd_data;

  // sequencer result toward the output register
  logic    res_valid;
  logic    res_ready;
  result_t res;

  // output register
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  logic in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;

  ckit_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_opcode   (in_ch.opcode),
    .in_column   (in_ch.column),
    .in_row_key  (in_ch.row_key),
    .in_value_in (in_ch.value_in),
    .in_ready    (in_ch.ready),
    .mem_ctl     (mem_ctl),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_data     (rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // entries: column, row and value side by side in one word
  ckit_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // the slot is free when empty or when its beat leaves this cycle
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.hit       = out_res_r.hit;
  assign out_ch.value_out = out_res_r.value_out;
  assign out_ch.status    = out_res_r.status;

endmodule

// File: rtl/core/ckit_checker.sv
// port-level checks for coordinate_keyed_index_table, bound to the top level
// depends on ckit_pkg and coordinate_keyed_index_table_macros.svh
`include "coordinate_keyed_index_table_macros.svh"

module ckit_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic [31:0] out_value_out,
  input logic [1:0]  out_status
);
  import ckit_pkg::*;

  // a held result beat keeps its payload
  `CKIT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_hit) && $stable(out_value_out) && $stable(out_status), "result beat changed while stalled")

  // one item in flight: taking a beat closes the input
  `CKIT_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "input open right after a beat was taken")

  // only a lookup hit carries a value
  `CKIT_ASSERT_IMP(a_value_zero, out_valid && (!out_hit || out_status != STAT_LOOKUP), out_value_out == 32'd0, "value on a result that is not a lookup hit")

  // an update always found its key
  `CKIT_ASSERT_IMP(a_update_hit, out_valid && out_status == STAT_UPDATE, out_hit, "update without a hit")

  // appends and drops never found their key
  `CKIT_ASSERT_IMP(a_append_miss, out_valid && (out_status == STAT_APPEND || out_status == STAT_FULL), !out_hit, "append or drop with a hit")

endmodule

bind coordinate_keyed_index_table ckit_checker u_ckit_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_hit       (out_ch.hit),
  .out_value_out (out_ch.value_out),
  .out_status    (out_ch.status)
);
